>>> src/tcc_pkg.sv
package tcc_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  // Configuration register map.
  localparam int unsigned APB_AW = 2;
  localparam logic [APB_AW-1:0] ADDR_MIN_AREA_DET = 2'd0;
  localparam logic [31:0] MIN_AREA_DET_RST = 32'd1;

  // Saturation limits.
  localparam logic [62:0] RADIUS_MAX = {63{1'b1}};
  localparam logic [31:0] CENTER_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] CENTER_MIN = 32'h8000_0000;

endpackage

>>> src/tcc_if.sv
interface tcc_in_if #(
  parameter int CoordBits = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] ax;
  logic signed [CoordBits-1:0] ay;
  logic signed [CoordBits-1:0] bx;
  logic signed [CoordBits-1:0] by;
  logic signed [CoordBits-1:0] cx;
  logic signed [CoordBits-1:0] cy;

  modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
  modport sink (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

interface tcc_out_if;
  import tcc_pkg::*;
  logic               valid;
  logic               ready;
  status_e            status;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [62:0]        radius_sq;

  modport source (output valid, status, center_x, center_y, radius_sq, input ready);
  modport sink (input valid, status, center_x, center_y, radius_sq, output ready);
endinterface

>>> src/triangle_circumcircle_top.sv
// Triangle circumcircle engine.
//
// Requests arrive on pt_i (valid/ready) and carry the three corner points
// of a triangle as signed integers. Each request yields exactly one result
// on res_o: a status, the circumcentre with FRAC_BITS fraction bits and the
// squared radius with 2*FRAC_BITS fraction bits, saturating where needed.
// The threshold min_area_det is written over the APB port at address 0.
//
// The block is a single pipeline and accepts one request in every cycle
// while the output register is empty or being taken; most of the pipeline
// is the bit-per-stage divider, one stage per quotient bit.
//
// All stages advance together while the output register is empty or being
// taken. When the receiver stalls with a result waiting, the whole pipeline
// holds and pt_i.ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and sets min_area_det to 1.
module triangle_circumcircle_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tcc_in_if.sink                     pt_i,
  tcc_out_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tcc_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int SW   = CB + 1;        // edge vectors and coordinate sums
  localparam int PW   = 2 * CB + 2;    // first products
  localparam int EW   = 2 * CB + 3;    // E and F
  localparam int GW   = 2 * CB + 4;    // G, four times the signed area
  localparam int NW   = 3 * CB + 5;    // centre numerators
  localparam int DVW  = NW + FRAC_BITS;
  localparam int QEW  = (DVW > 42) ? DVW : 42;
  localparam int CW   = (GW > 32) ? GW : 32;

  // Configuration register.
  logic [31:0] min_area_q;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MIN_AREA_DET) ? min_area_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_area_q <= MIN_AREA_DET_RST;
    end else if (psel && penable && pwrite && (paddr == ADDR_MIN_AREA_DET)) begin
      min_area_q <= pwdata;
    end
  end

  // Global advance: the output register is free or is being drained.
  logic en;
  logic out_v_q;

  assign en       = !out_v_q || res_o.ready;
  assign pt_i.ready = en;

  // Stage 1: edge vectors and coordinate sums.
  logic              v1_q;
  logic signed [SW-1:0] a1_q, b1_q, c1_q, d1_q;
  logic signed [SW-1:0] sab_q, syb_q, sac_q, syc_q, dyc_q, dxc_q;
  logic signed [CB-1:0] ax1_q, ay1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q  <= SW'(pt_i.bx) - SW'(pt_i.ax);
      b1_q  <= SW'(pt_i.by) - SW'(pt_i.ay);
      c1_q  <= SW'(pt_i.cx) - SW'(pt_i.ax);
      d1_q  <= SW'(pt_i.cy) - SW'(pt_i.ay);
      sab_q <= SW'(pt_i.ax) + SW'(pt_i.bx);
      syb_q <= SW'(pt_i.ay) + SW'(pt_i.by);
      sac_q <= SW'(pt_i.ax) + SW'(pt_i.cx);
      syc_q <= SW'(pt_i.ay) + SW'(pt_i.cy);
      dyc_q <= SW'(pt_i.cy) - SW'(pt_i.by);
      dxc_q <= SW'(pt_i.cx) - SW'(pt_i.bx);
      ax1_q <= pt_i.ax;
      ay1_q <= pt_i.ay;
    end
  end

  // Stage 2: the six first-level products.
  logic              v2_q;
  logic signed [PW-1:0] pa2_q, pb2_q, pc2_q, pd2_q, pg1_q, pg2_q;
  logic signed [SW-1:0] a2_q, b2_q, c2_q, d2_q;
  logic signed [CB-1:0] ax2_q, ay2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa2_q <= PW'(a1_q) * PW'(sab_q);
      pb2_q <= PW'(b1_q) * PW'(syb_q);
      pc2_q <= PW'(c1_q) * PW'(sac_q);
      pd2_q <= PW'(d1_q) * PW'(syc_q);
      pg1_q <= PW'(a1_q) * PW'(dyc_q);
      pg2_q <= PW'(b1_q) * PW'(dxc_q);
      a2_q  <= a1_q;
      b2_q  <= b1_q;
      c2_q  <= c1_q;
      d2_q  <= d1_q;
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;
    end
  end

  // Stage 3: E, F and G.
  logic              v3_q;
  logic signed [EW-1:0] e3_q, f3_q;
  logic signed [GW-1:0] g3_q;
  logic signed [SW-1:0] a3_q, b3_q, c3_q, d3_q;
  logic signed [CB-1:0] ax3_q, ay3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e3_q  <= EW'(pa2_q) + EW'(pb2_q);
      f3_q  <= EW'(pc2_q) + EW'(pd2_q);
      g3_q  <= (GW'(pg1_q) - GW'(pg2_q)) <<< 1;
      a3_q  <= a2_q;
      b3_q  <= b2_q;
      c3_q  <= c2_q;
      d3_q  <= d2_q;
      ax3_q <= ax2_q;
      ay3_q <= ay2_q;
    end
  end

  // Stage 4: numerator products, divisor magnitude and degenerate test.
  logic              v4_q;
  logic signed [NW-1:0] de4_q, bf4_q, af4_q, ce4_q;
  logic [GW-1:0]        gm4_q;
  logic                 gneg4_q, degen4_q;
  logic signed [CB-1:0] ax4_q, ay4_q;
  logic [GW-1:0]        gmag3;

  assign gmag3 = g3_q[GW-1] ? GW'(-g3_q) : GW'(g3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      de4_q    <= NW'(d3_q) * NW'(e3_q);
      bf4_q    <= NW'(b3_q) * NW'(f3_q);
      af4_q    <= NW'(a3_q) * NW'(f3_q);
      ce4_q    <= NW'(c3_q) * NW'(e3_q);
      gm4_q    <= gmag3;
      gneg4_q  <= g3_q[GW-1];
      degen4_q <= (gmag3 == '0) || (CW'(gmag3) < CW'(min_area_q));
      ax4_q    <= ax3_q;
      ay4_q    <= ay3_q;
    end
  end

  // Stage 5: numerators as sign and scaled magnitude.
  logic              v5_q;
  logic [DVW-1:0]       nxm5_q, nym5_q;
  logic [GW-1:0]        gm5_q;
  logic                 xs5_q, ys5_q, gneg5_q, degen5_q;
  logic signed [CB-1:0] ax5_q, ay5_q;
  logic signed [NW-1:0] nx4, ny4;

  assign nx4 = de4_q - bf4_q;
  assign ny4 = af4_q - ce4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nxm5_q   <= DVW'(nx4[NW-1] ? NW'(-nx4) : NW'(nx4)) << FRAC_BITS;
      nym5_q   <= DVW'(ny4[NW-1] ? NW'(-ny4) : NW'(ny4)) << FRAC_BITS;
      xs5_q    <= nx4[NW-1];
      ys5_q    <= ny4[NW-1];
      gm5_q    <= gm4_q;
      gneg5_q  <= gneg4_q;
      degen5_q <= degen4_q;
      ax5_q    <= ax4_q;
      ay5_q    <= ay4_q;
    end
  end

  // Divider stages, one per quotient bit, with the side data alongside.
  typedef struct packed {
    logic                 degen;
    logic                 xneg;
    logic                 yneg;
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
  } side_t;

  logic           side_v_q [DVW];
  side_t          side_q [DVW];
  logic [DVW-1:0] qx, qy;

  tcc_div #(.NumW(DVW), .DenW(GW)) u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (nxm5_q),
    .den_i  (gm5_q),
    .quot_o (qx)
  );

  tcc_div #(.NumW(DVW), .DenW(GW)) u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (nym5_q),
    .den_i  (gm5_q),
    .quot_o (qy)
  );

  for (genvar k = 0; k < DVW; k++) begin : g_side
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          side_v_q[k] <= 1'b0;
        end else if (en) begin
          side_v_q[k] <= v5_q;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          side_q[k].degen <= degen5_q;
          side_q[k].xneg  <= xs5_q ^ gneg5_q;
          side_q[k].yneg  <= ys5_q ^ gneg5_q;
          side_q[k].ax    <= ax5_q;
          side_q[k].ay    <= ay5_q;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          side_v_q[k] <= 1'b0;
        end else if (en) begin
          side_v_q[k] <= side_v_q[k-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  // Post stage 1: clamp the centre and form the distance to point a.
  typedef struct packed {
    logic [31:0] cval;
    logic        csat;
    logic [31:0] m;
    logic        mov;
  } post_t;

  function automatic post_t post_coord(input logic [QEW-1:0] qe, input logic neg_in,
                                       input logic signed [CB-1:0] a);
    post_t                r;
    logic                 neg;
    logic signed [41:0]   qv;
    logic signed [41:0]   afix;
    logic signed [42:0]   diff;
    logic [42:0]          mag;
    neg    = neg_in && (qe != '0);
    r.csat = neg ? (qe > QEW'(64'h8000_0000)) : (qe > QEW'(64'h7FFF_FFFF));
    if (r.csat) begin
      r.cval = neg ? CENTER_MIN : CENTER_MAX;
    end else begin
      r.cval = neg ? 32'(~qe[31:0] + 32'd1) : qe[31:0];
    end
    qv    = neg ? -$signed({2'b00, qe[39:0]}) : $signed({2'b00, qe[39:0]});
    afix  = 42'(a) <<< FRAC_BITS;
    diff  = 43'(afix) - 43'(qv);
    mag   = diff[42] ? 43'(-diff) : 43'(diff);
    r.m   = mag[31:0];
    r.mov = (qe >= QEW'(64'h100_0000_0000)) || (mag[42:32] != '0);
    return r;
  endfunction

  logic  p1_v_q, p1_degen_q;
  post_t px1_q, py1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q      <= post_coord(QEW'(qx), side_q[DVW-1].xneg, side_q[DVW-1].ax);
      py1_q      <= post_coord(QEW'(qy), side_q[DVW-1].yneg, side_q[DVW-1].ay);
      p1_degen_q <= side_q[DVW-1].degen;
    end
  end

  // Post stage 2: squares of the distances.
  logic        p2_v_q, p2_degen_q, p2_csat_q, p2_ov_q;
  logic [63:0] sqx2_q, sqy2_q;
  logic [31:0] cx2_q, cy2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx2_q     <= 64'(px1_q.m) * 64'(px1_q.m);
      sqy2_q     <= 64'(py1_q.m) * 64'(py1_q.m);
      cx2_q      <= px1_q.cval;
      cy2_q      <= py1_q.cval;
      p2_csat_q  <= px1_q.csat || py1_q.csat;
      p2_ov_q    <= px1_q.mov || py1_q.mov;
      p2_degen_q <= p1_degen_q;
    end
  end

  // Post stage 3 (output register): radius sum and status.
  logic [64:0] rsum;
  logic        rsat;
  status_e     status_q;
  logic signed [31:0] cx_out_q, cy_out_q;
  logic [62:0] rad_q;

  assign rsum = 65'(sqx2_q) + 65'(sqy2_q);
  assign rsat = p2_ov_q || (rsum > 65'(RADIUS_MAX));

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (p2_degen_q) begin
        status_q <= ST_DEGEN;
        cx_out_q <= '0;
        cy_out_q <= '0;
        rad_q    <= '0;
      end else begin
        status_q <= (rsat || p2_csat_q) ? ST_SAT : ST_OK;
        cx_out_q <= cx2_q;
        cy_out_q <= cy2_q;
        rad_q    <= rsat ? RADIUS_MAX : rsum[62:0];
      end
    end
  end

  // Valid bits outside the divider section.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= pt_i.valid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      p1_v_q  <= side_v_q[DVW-1];
      p2_v_q  <= p1_v_q;
      out_v_q <= p2_v_q;
    end
  end

  assign res_o.valid     = out_v_q;
  assign res_o.status    = status_q;
  assign res_o.center_x  = cx_out_q;
  assign res_o.center_y  = cy_out_q;
  assign res_o.radius_sq = rad_q;

endmodule

>>> src/tcc_div.sv
// Pipelined restoring divider: one quotient bit per stage, all stages
// advance together when en_i is high.
module tcc_div #(
  parameter int NumW = 61,
  parameter int DenW = 36
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quot_o
);

  logic [DenW-1:0] rem_q [NumW];
  logic [NumW-1:0] nq_q  [NumW];
  logic [DenW-1:0] den_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [DenW-1:0] rem_in;
    logic [NumW-1:0] nq_in;
    logic [DenW-1:0] den_in;
    logic [DenW:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, nq_in[NumW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DenW'(trial - {1'b0, den_in}) : trial[DenW-1:0];
        nq_q[k]  <= {nq_in[NumW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quot_o = nq_q[NumW-1];

endmodule
